[rtl/core/pesb_pkg.sv]
// shared constants, types and the reciprocal table of the speed smoothing bank
package pesb_pkg;

  localparam int EDGE_COUNT  = 1024;
  localparam int EDGE_W      = 10;
  localparam int MAX_WINDOW  = 16;
  localparam int SLOT_W      = 4;
  localparam int LEN_W       = 5;
  localparam int SPD_W       = 16;
  localparam int WGT_W       = 16;
  // a running sum can reach 17 full-scale speeds after mode changes
  localparam int LVL_W       = 21;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = 22;

  // input item commands
  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_END    = 2'd2,
    CMD_NONE   = 2'd3
  } pesb_cmd_t;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_STEPS  = 2'd0;
  localparam logic [1:0] CFG_SMOOTH_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_BIKE_ENABLE   = 2'd2;
  localparam logic [1:0] CFG_SPARE         = 2'd3;

  // window slots of one edge, slot k in element k
  typedef logic [MAX_WINDOW-1:0][SPD_W-1:0] pesb_row_t;

  // control from the sequencer to one smoothing lane
  typedef struct packed {
    logic              rd_en;
    logic [EDGE_W-1:0] rd_addr;
    logic              wr_en;
    logic [EDGE_W-1:0] wr_addr;
    logic              is_init;
    logic              ma_mode;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic [WGT_W-1:0]  weight;
    logic              st_read;
    logic              st_calc;
    logic              st_fix;
  } pesb_ctrl_t;

  // floor(2^21 / len) for window lengths 1 to 16
  function automatic logic [RECIP_W-1:0] pesb_recip(input logic [LEN_W-1:0] len);
    logic [RECIP_W-1:0] r;
    unique case (len)
      5'd1:    r = 22'd2097152;
      5'd2:    r = 22'd1048576;
      5'd3:    r = 22'd699050;
      5'd4:    r = 22'd524288;
      5'd5:    r = 22'd419430;
      5'd6:    r = 22'd349525;
      5'd7:    r = 22'd299593;
      5'd8:    r = 22'd262144;
      5'd9:    r = 22'd233016;
      5'd10:   r = 22'd209715;
      5'd11:   r = 22'd190650;
      5'd12:   r = 22'd174762;
      5'd13:   r = 22'd161319;
      5'd14:   r = 22'd149796;
      5'd15:   r = 22'd139810;
      5'd16:   r = 22'd131072;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/pesb_lane.sv]
// one smoothing lane: per-edge window and level memory with its arithmetic
module pesb_lane import pesb_pkg::*; (
  input  logic             clk,
  input  pesb_ctrl_t       ctrl,
  input  logic [SPD_W-1:0] speed,
  output logic [SPD_W-1:0] result
);

  localparam int ROW_W  = $bits(pesb_row_t);
  localparam int MEM_W  = ROW_W + LVL_W;
  localparam int PROD_W = SPD_W + WGT_W + 2;
  localparam int MUL_W  = LVL_W + RECIP_W - 1;

  logic [MEM_W-1:0] mem [EDGE_COUNT];
  logic [MEM_W-1:0] rdata;
  logic [MEM_W-1:0] wdata;

  pesb_row_t          row_in, row_new, row_reg;
  logic [LVL_W-1:0]   lvl_in, lvl_drop, sum_new, init_prod, lvl_sel, lvl_reg, lvl_wr;
  logic [SPD_W-1:0]   old_slot, old_sat, exp_lvl, q_sat;
  logic signed [SPD_W:0]    diff;
  logic signed [PROD_W-1:0] diff_ext, wgt_ext, exp_prod, prod_reg, exp_acc;
  logic [MUL_W-1:0]   mul_reg;
  logic [LVL_W-1:0]   q0, q_len, rem, q;
  logic               exp_update, ma_update;

  // memory: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata <= mem[ctrl.rd_addr];
    end
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wdata;
    end
  end

  assign exp_update = !ctrl.is_init && !ctrl.ma_mode;
  assign ma_update  = !ctrl.is_init && ctrl.ma_mode;

  // read stage: unpack, replace slot, adjust sum, start smoothing product
  always_comb begin
    row_in    = rdata[ROW_W-1:0];
    lvl_in    = rdata[MEM_W-1 -: LVL_W];
    old_slot  = row_in[ctrl.slot];
    lvl_drop  = (lvl_in < LVL_W'(old_slot)) ? '0 : lvl_in - LVL_W'(old_slot);
    sum_new   = lvl_drop + LVL_W'(speed);
    init_prod = LVL_W'(speed) * LVL_W'(ctrl.len);
    old_sat   = (|lvl_in[LVL_W-1:SPD_W]) ? '1 : lvl_in[SPD_W-1:0];
    // old minus current, weighted, added to the current speed
    diff      = $signed({1'b0, old_sat}) - $signed({1'b0, speed});
    diff_ext  = PROD_W'(diff);
    wgt_ext   = $signed(PROD_W'({1'b0, ctrl.weight}));
    exp_prod  = diff_ext * wgt_ext;
    row_new   = row_in;
    if (ctrl.is_init) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        row_new[k] = speed;
      end
      lvl_sel = ctrl.ma_mode ? init_prod : LVL_W'(speed);
    end else begin
      if (ctrl.ma_mode) begin
        row_new[ctrl.slot] = speed;
      end
      lvl_sel = sum_new;
    end
  end

  // calc stage: finish smoothing, write back
  always_comb begin
    exp_acc = $signed({2'b00, speed, {WGT_W{1'b0}}}) + prod_reg
            + $signed(PROD_W'(32768));
    exp_lvl = exp_acc[SPD_W+WGT_W-1:WGT_W];
    lvl_wr  = exp_update ? LVL_W'(exp_lvl) : lvl_reg;
    wdata   = {lvl_wr, row_reg};
  end

  // fix stage: reciprocal quotient with one correction step
  always_comb begin
    q0    = mul_reg[MUL_W-1:RECIP_SHIFT];
    q_len = q0 * LVL_W'(ctrl.len);
    rem   = lvl_reg - q_len;
    q     = (rem >= LVL_W'(ctrl.len)) ? q0 + 1'b1 : q0;
    q_sat = (|q[LVL_W-1:SPD_W]) ? '1 : q[SPD_W-1:0];
  end

  // stage registers and lane result
  always_ff @(posedge clk) begin
    if (ctrl.st_read) begin
      row_reg  <= row_new;
      lvl_reg  <= lvl_sel;
      prod_reg <= exp_prod;
      if (ctrl.is_init) begin
        result <= speed;
      end
    end
    if (ctrl.st_calc) begin
      mul_reg <= MUL_W'(MUL_W'(lvl_reg) * MUL_W'(pesb_recip(ctrl.len)));
      if (exp_update) begin
        result <= exp_lvl;
      end
    end
    if (ctrl.st_fix && ma_update) begin
      result <= q_sat;
    end
  end

endmodule

[rtl/core/per_edge_speed_smoothing_bank_top.sv]
// top level of the per-edge speed smoothing bank: sequencer, config and output register
//
// Keeps a smoothed car speed and, when bike_enable is set, a bike speed per edge.
// Input items arrive on s_tvalid/s_tready: s_tuser carries the command (init,
// update, end of interval), s_tdata the edge and the two Q8.8 speeds. Results
// leave on m_tvalid/m_tready, one per input item, in order.
// Configuration goes over cfg_valid/cfg_ready (always ready) by register index:
// 0 window length, 1 smoothing weight, 2 bike enable.
// Init and update items read the edge's row of window slots and level, then pass
// the read, calc and fix states (sum or smoothing product, then reciprocal quotient
// and its correction), and the done state moves the result into the output register;
// the next item can be taken in the cycle after that.
// End and unknown items touch no memory and go straight from idle to the done state.
// Reset clears the slot index, the configuration and the sequencer; the
// per-edge memories are not cleared and hold no meaning until an init item.
// When the receiver stalls, one result waits in the output register while the
// next item is accepted and worked; that item then waits until the output frees.
module per_edge_speed_smoothing_bank_top import pesb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // edge_id [9:0], car_speed [25:10], bike_speed [41:26], zero fill
  input  logic [47:0] s_tdata,
  // cmd [1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_edge [9:0], avg_car_speed [25:10], avg_bike_speed [41:26], slot_now [45:42], zero fill
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_FIX,
    ST_DONE
  } state_t;

  state_t            state;
  pesb_cmd_t         cmd_in, cmd_r;
  logic [EDGE_W-1:0] edge_r;
  logic [SPD_W-1:0]  car_r, bike_r, car_res, bike_res, avg_car, avg_bike;
  logic [SLOT_W-1:0] slot_index, slot_r;
  logic [LEN_W-1:0]  window_steps, len_eff, slot_nx;
  logic [WGT_W-1:0]  smooth_weight;
  logic              bike_enable;
  logic              in_acc, edge_cmd, edge_cmd_r;
  logic [EDGE_W-1:0] out_edge;
  pesb_ctrl_t        car_ctrl, bike_ctrl;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign cmd_in    = pesb_cmd_t'(s_tuser);
  assign edge_cmd  = (cmd_in == CMD_INIT) || (cmd_in == CMD_UPDATE);
  assign edge_cmd_r = (cmd_r == CMD_INIT) || (cmd_r == CMD_UPDATE);
  assign len_eff   = (window_steps > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : window_steps;
  assign slot_nx   = {1'b0, slot_index} + 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_steps  <= '0;
      smooth_weight <= '0;
      bike_enable   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_STEPS:  window_steps  <= cfg_data[LEN_W-1:0];
        CFG_SMOOTH_WEIGHT: smooth_weight <= cfg_data[WGT_W-1:0];
        CFG_BIKE_ENABLE:   bike_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // lane control
  always_comb begin
    car_ctrl.rd_en   = in_acc && edge_cmd;
    car_ctrl.rd_addr = s_tdata[EDGE_W-1:0];
    car_ctrl.wr_en   = (state == ST_CALC);
    car_ctrl.wr_addr = edge_r;
    car_ctrl.is_init = (cmd_r == CMD_INIT);
    car_ctrl.ma_mode = (len_eff != '0);
    car_ctrl.slot    = slot_r;
    car_ctrl.len     = len_eff;
    car_ctrl.weight  = smooth_weight;
    car_ctrl.st_read = (state == ST_READ);
    car_ctrl.st_calc = (state == ST_CALC);
    car_ctrl.st_fix  = (state == ST_FIX);
    bike_ctrl        = car_ctrl;
    bike_ctrl.rd_en  = car_ctrl.rd_en && bike_enable;
    bike_ctrl.wr_en  = car_ctrl.wr_en && bike_enable;
  end

  pesb_lane u_car_lane (
    .clk    (clk),
    .ctrl   (car_ctrl),
    .speed  (car_r),
    .result (car_res)
  );

  pesb_lane u_bike_lane (
    .clk    (clk),
    .ctrl   (bike_ctrl),
    .speed  (bike_r),
    .result (bike_res)
  );

  // result fields
  always_comb begin
    out_edge = edge_cmd_r ? edge_r : '0;
    avg_car  = edge_cmd_r ? car_res : '0;
    avg_bike = (edge_cmd_r && bike_enable) ? bike_res : '0;
  end

  // sequencer, slot index and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_index <= '0;
      m_tvalid   <= 1'b0;
      cmd_r      <= CMD_NONE;
    end else begin
      // the done state reloads the output register itself
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r  <= cmd_in;
            edge_r <= s_tdata[EDGE_W-1:0];
            car_r  <= s_tdata[EDGE_W +: SPD_W];
            bike_r <= s_tdata[EDGE_W+SPD_W +: SPD_W];
            slot_r <= ({1'b0, slot_index} < len_eff) ? slot_index : '0;
            if (edge_cmd) begin
              state <= ST_READ;
            end else begin
              if (cmd_in == CMD_END && len_eff != '0) begin
                slot_index <= (slot_nx >= len_eff) ? '0 : slot_nx[SLOT_W-1:0];
              end
              state <= ST_DONE;
            end
          end
        end
        ST_READ: state <= ST_CALC;
        ST_CALC: state <= ST_FIX;
        ST_FIX:  state <= ST_DONE;
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, slot_index, avg_bike, avg_car, out_edge};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
